/* sv/pcd_pkg.sv */
// ----------------------------------------------------------------------------
// pcd_pkg - shared types and constants
// Sequencer states, fixed-point constants and register indexes for the
// positional/incremental PID controller.
// ----------------------------------------------------------------------------
package pcd_pkg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FFCHK,
        ST_FF1W,
        ST_DIVW,
        ST_FF2W,
        ST_FF3W,
        ST_PW,
        ST_IW,
        ST_IPW,
        ST_IIW,
        ST_D,
        ST_KW,
        ST_T1W,
        ST_T2W,
        ST_T3W,
        ST_DW,
        ST_SUM1,
        ST_SUM2,
        ST_SUM3,
        ST_OUT
    } t_state;

    typedef logic [2:0] t_reg_idx;
    typedef logic [1:0] t_opt;

    // register indexes
    localparam t_reg_idx REG_MODE     = 3'd0;
    localparam t_reg_idx REG_GAIN_P   = 3'd1;
    localparam t_reg_idx REG_GAIN_I   = 3'd2;
    localparam t_reg_idx REG_GAIN_D   = 3'd3;
    localparam t_reg_idx REG_LIMITS   = 3'd4;
    localparam t_reg_idx REG_GAIN_FF  = 3'd5;
    localparam t_reg_idx REG_FF_KNEE  = 3'd6;
    localparam t_reg_idx REG_FF_LIMIT = 3'd7;

    // derivative / integral options (mode bits 2:1)
    localparam t_opt OPT_PLAIN = 2'd0;
    localparam t_opt OPT_FILT  = 2'd1;
    localparam t_opt OPT_SEP   = 2'd2;
    localparam t_opt OPT_FORCE = 2'd3;

    // Q16.16 constants
    localparam logic signed [31:0] K_A   = 32'sd52429;  // 0.8
    localparam logic signed [31:0] K_OMA = 32'sd13107;  // 0.2
    localparam logic signed [31:0] K_SEP = 32'sd6554;   // 0.10
    localparam logic [32:0]        Q_ONE = 33'd65536;   // 1.0

    localparam int MUL_STEPS = 32;
    localparam int DIV_STEPS = 48;

endpackage

/* sv/pcd_if.sv */
// ----------------------------------------------------------------------------
// pcd_if - valid/ready channels
// Input channel (command, set point, measurement) and output channel (drive).
// ----------------------------------------------------------------------------
interface pcd_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [31:0] target_value;
    logic signed [31:0] measured_value;

    modport source (output valid, output cmd, output target_value,
                    output measured_value, input ready);
    modport sink   (input valid, input cmd, input target_value,
                    input measured_value, output ready);
endinterface

interface pcd_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] drive_out;

    modport source (output valid, output drive_out, input ready);
    modport sink   (input valid, input drive_out, output ready);
endinterface

/* sv/pcd_mul.sv */
// ----------------------------------------------------------------------------
// pcd_mul - bit-serial Q16.16 multiplier
// Shift-add over the 32 bits of the coefficient magnitude, one bit a cycle,
// then truncation toward zero by 16 bits and saturation to DATA_WIDTH.
// ----------------------------------------------------------------------------
module pcd_mul import pcd_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [((DATA_WIDTH > 32) ? DATA_WIDTH : 32)-1:0] i_a,
    input  logic signed [31:0]            i_c,
    output logic                          o_done,
    output logic signed [DATA_WIDTH-1:0]  o_res
);
    localparam int AW = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
    localparam int PW = AW + 32;
    localparam int CNTW = $clog2(MUL_STEPS);
    localparam logic [AW+15:0] MAG_POS =
        {{(AW + 17 - DATA_WIDTH){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic [AW+15:0] MAG_NEG = MAG_POS + 1'b1;

    logic                  r_busy, r_fin, r_done, r_neg;
    logic [CNTW-1:0]       r_cnt;
    logic [AW-1:0]         r_ua;
    logic [PW-1:0]         r_acc;
    logic signed [DATA_WIDTH-1:0] r_res;

    logic [AW-1:0]         w_ua;
    logic [31:0]           w_uc;
    logic [AW:0]           w_sum;
    logic [AW+15:0]        w_m;
    logic signed [DATA_WIDTH-1:0] w_sat;

    assign w_ua  = i_a[AW-1] ? (~i_a + 1'b1) : i_a;
    assign w_uc  = i_c[31]   ? (~i_c + 1'b1) : i_c;
    assign w_sum = {1'b0, r_acc[PW-1:32]} + (r_acc[0] ? {1'b0, r_ua} : {(AW+1){1'b0}});
    assign w_m   = r_acc[PW-1:16];

    always_comb begin
        if (r_neg) begin
            w_sat = (w_m >= MAG_NEG) ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                                     : -$signed(w_m[DATA_WIDTH-1:0]);
        end else begin
            w_sat = (w_m > MAG_POS) ? {1'b0, {(DATA_WIDTH-1){1'b1}}}
                                    : $signed(w_m[DATA_WIDTH-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_ua   <= w_ua;
                r_acc  <= {{AW{1'b0}}, w_uc};
                r_neg  <= i_a[AW-1] ^ i_c[31];
            end else if (r_busy) begin
                r_acc <= {w_sum, r_acc[31:1]};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNTW'(MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
                r_res  <= w_sat;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy && !r_fin)
        else $error("multiplier restarted while busy");

    a_busy_fin_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_fin))
        else $error("multiplier busy and finishing at once");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("multiplier done held longer than one cycle");

endmodule

/* sv/pid_controller_pos_delta.sv */
// ----------------------------------------------------------------------------
// pid_controller_pos_delta - positional / incremental PID controller
// Q16.16 PID with incomplete-derivative filter, integral separation and a
// speed-dependent feedforward, built around one bit-serial multiplier.
// ----------------------------------------------------------------------------
// Sequencing: a clear transaction goes from idle to the output state. A
//   control step runs 3 to 8 multiplies in turn on the serial multiplier,
//   the feedforward divide when it runs, then three summing states and the output state.
// Throughput: one transaction at a time; the input is ready only while idle.
// Reset (i_rst_n low, synchronous): config, history and control state zeroed.
// ----------------------------------------------------------------------------
module pid_controller_pos_delta import pcd_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pcd_in_if.sink      i_in,
    pcd_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);
    localparam int W   = DATA_WIDTH;
    localparam int AW  = (W > 32) ? W : 32;           // multiplier operand
    localparam int XW  = ((W > 33) ? W : 33) + 2;     // headroom for sums
    localparam int DCW = $clog2(DIV_STEPS);

    localparam logic signed [XW-1:0] V_MAX = XW'({1'b0, {(W-1){1'b1}}});
    localparam logic signed [XW-1:0] V_MIN = ~V_MAX;
    localparam logic signed [XW-1:0] D_MAX = XW'(33'sh0_7FFF_FFFF);
    localparam logic signed [XW-1:0] D_MIN = ~D_MAX;

    // ---------------- saturating helpers ----------------
    function automatic logic signed [W-1:0] sat_w(input logic signed [XW-1:0] v);
        if (v > V_MAX) return V_MAX[W-1:0];
        if (v < V_MIN) return V_MIN[W-1:0];
        return v[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] add_s(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
        return sat_w(XW'(a) + XW'(b));
    endfunction

    function automatic logic signed [W-1:0] sub_s(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
        return sat_w(XW'(a) - XW'(b));
    endfunction

    // clamp to +/- m, m an unsigned magnitude
    function automatic logic signed [W-1:0] clamp_m(input logic signed [W-1:0] v,
                                                    input logic [31:0] m);
        logic signed [XW-1:0] ve;
        logic signed [XW-1:0] me;
        ve = XW'(v);
        me = XW'({1'b0, m});
        if (ve > me)  return me[W-1:0];
        if (ve < -me) return W'(-me);
        return v;
    endfunction

    // ---------------- configuration ----------------
    logic [2:0]         r_mode;
    logic signed [31:0] r_gp, r_gi, r_gd, r_gff, r_knee;
    logic [31:0]        r_lim_i, r_lim_o;
    logic [30:0]        r_ffl;

    // ---------------- controller state ----------------
    logic signed [W-1:0] r_eh0, r_eh1, r_eh2;   // error history
    logic signed [W-1:0] r_dh0, r_dh1;          // difference history
    logic signed [W-1:0] r_int, r_prevd, r_ff, r_outr;

    // working registers
    logic signed [31:0]  r_set;
    logic signed [W-1:0] r_p;    // P, then running sum
    logic signed [W-1:0] r_acc;  // derivative term being built
    logic signed [W-1:0] r_k;    // gain_d * 0.2
    t_state              r_state, n_state;
    logic                r_ovalid;
    logic signed [31:0]  r_drive;

    // divider
    logic [33:0]    r_rem;
    logic [47:0]    r_dq;
    logic [32:0]    r_dden;
    logic [DCW-1:0] r_dcnt;
    logic           r_dbusy, r_ddone;
    logic [33:0]    w_rem_sh;
    logic           w_ge;

    // multiplier hookup
    logic                 mul_start, mul_done, div_start;
    logic signed [AW-1:0] mul_a;
    logic signed [31:0]   mul_c;
    logic signed [W-1:0]  mul_res;

    logic        w_acc, w_filt, w_sep, w_free;
    t_opt        w_opt;
    logic [31:0] w_as, w_ak;
    logic signed [XW-1:0] w_oe;
    logic signed [31:0]   w_drive;

    pcd_mul #(.DATA_WIDTH(DATA_WIDTH)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_c     (mul_c),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    assign w_acc  = i_in.valid && i_in.ready;
    assign w_opt  = r_mode[2:1];
    // the filter runs on option 1, and also on option 3 in incremental form
    assign w_filt = r_mode[0] ? (w_opt == OPT_FILT || w_opt == OPT_FORCE)
                              : (w_opt == OPT_FILT);
    // integral separation (incremental mode): drop I when |e0| exceeds 0.10
    assign w_sep  = (w_opt == OPT_SEP) &&
                    (XW'(r_eh0) > XW'(K_SEP) || XW'(r_eh0) < -XW'(K_SEP));
    assign w_as   = r_set[31]  ? (~r_set + 1'b1)  : r_set;
    assign w_ak   = r_knee[31] ? (~r_knee + 1'b1) : r_knee;
    assign w_free = !r_ovalid || o_out.ready;

    // output saturates to 32 bits when DATA_WIDTH is wider
    assign w_oe    = XW'(r_outr);
    assign w_drive = (w_oe > D_MAX) ? D_MAX[31:0] :
                     (w_oe < D_MIN) ? D_MIN[31:0] : w_oe[31:0];

    // restoring divide, one quotient bit a cycle
    assign w_rem_sh = {r_rem[32:0], r_dq[47]};
    assign w_ge     = w_rem_sh >= {1'b0, r_dden};

    assign i_in.ready      = (r_state == ST_IDLE);
    assign o_out.valid     = r_ovalid;
    assign o_out.drive_out = r_drive;

    // ---------------- sequencer: next state and unit launches ----------------
    always_comb begin
        n_state   = r_state;
        mul_start = 1'b0;
        mul_a     = '0;
        mul_c     = '0;
        div_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) n_state = i_in.cmd ? ST_OUT : ST_FFCHK;
            end
            ST_FFCHK: begin
                mul_a = AW'(r_eh0);
                mul_c = r_gp;
                if (r_mode[0]) begin
                    mul_start = 1'b1;
                    mul_a     = AW'(sub_s(r_eh0, r_eh1));
                    n_state   = ST_IPW;
                end else if (w_as > w_ak) begin
                    mul_start = 1'b1;
                    mul_a     = AW'(r_set);
                    mul_c     = r_gff;
                    n_state   = ST_FF1W;
                end else if (r_knee != '0) begin
                    div_start = 1'b1;
                    n_state   = ST_DIVW;
                end else begin
                    mul_start = 1'b1;
                    n_state   = ST_PW;
                end
            end
            ST_FF1W, ST_FF3W: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = AW'(r_eh0);
                    mul_c     = r_gp;
                    n_state   = ST_PW;
                end
            end
            ST_DIVW: begin
                if (r_ddone) begin
                    mul_start = 1'b1;
                    mul_a     = AW'({1'b0, r_dq[16:0]});
                    mul_c     = r_gff;
                    n_state   = ST_FF2W;
                end
            end
            ST_FF2W: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = AW'(mul_res);
                    mul_c     = r_set;
                    n_state   = ST_FF3W;
                end
            end
            ST_PW, ST_IPW: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = AW'(r_eh0);
                    mul_c     = r_gi;
                    n_state   = (r_state == ST_PW) ? ST_IW : ST_IIW;
                end
            end
            ST_IW, ST_IIW: begin
                if (mul_done) n_state = ST_D;
            end
            ST_D: begin
                mul_start = 1'b1;
                if (w_filt) begin
                    mul_a   = AW'(r_gd);
                    mul_c   = K_OMA;
                    n_state = ST_KW;
                end else begin
                    mul_a   = AW'(r_dh0);
                    mul_c   = r_gd;
                    n_state = ST_DW;
                end
            end
            ST_KW: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = AW'(r_dh0);
                    mul_c     = 32'(mul_res);
                    n_state   = ST_T1W;
                end
            end
            ST_T1W: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = AW'(r_prevd);
                    mul_c     = K_A;
                    n_state   = ST_T2W;
                end
            end
            ST_T2W: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = AW'(r_dh1);
                    mul_c     = 32'(r_k);
                    n_state   = ST_T3W;
                end
            end
            ST_T3W, ST_DW: begin
                if (mul_done) n_state = ST_SUM1;
            end
            ST_SUM1: n_state = ST_SUM2;
            ST_SUM2: n_state = ST_SUM3;
            ST_SUM3: n_state = ST_OUT;
            ST_OUT: begin
                if (w_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // ---------------- configuration writes ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= '0;
            r_gp    <= '0;
            r_gi    <= '0;
            r_gd    <= '0;
            r_gff   <= '0;
            r_knee  <= '0;
            r_lim_i <= '0;
            r_lim_o <= '0;
            r_ffl   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODE:     r_mode  <= i_cfg_data[2:0];
                REG_GAIN_P:   r_gp    <= i_cfg_data[31:0];
                REG_GAIN_I:   r_gi    <= i_cfg_data[31:0];
                REG_GAIN_D:   r_gd    <= i_cfg_data[31:0];
                REG_LIMITS: begin
                    r_lim_i <= i_cfg_data[63:32];
                    r_lim_o <= i_cfg_data[31:0];
                end
                REG_GAIN_FF:  r_gff   <= i_cfg_data[31:0];
                REG_FF_KNEE:  r_knee  <= i_cfg_data[31:0];
                REG_FF_LIMIT: r_ffl   <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // ---------------- feedforward divider ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_ddone <= 1'b0;
        end else begin
            r_ddone <= 1'b0;
            if (div_start) begin
                r_dbusy <= 1'b1;
                r_dcnt  <= '0;
                r_rem   <= '0;
                r_dq    <= {w_as, 16'h0000};
                r_dden  <= {1'b0, w_ak} + Q_ONE;
            end else if (r_dbusy) begin
                r_rem  <= w_ge ? (w_rem_sh - {1'b0, r_dden}) : w_rem_sh;
                r_dq   <= {r_dq[46:0], w_ge};
                r_dcnt <= r_dcnt + 1'b1;
                if (r_dcnt == DCW'(DIV_STEPS - 1)) begin
                    r_dbusy <= 1'b0;
                    r_ddone <= 1'b1;
                end
            end
        end
    end

    // ---------------- datapath updates ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eh0    <= '0;
            r_eh1    <= '0;
            r_eh2    <= '0;
            r_dh0    <= '0;
            r_dh1    <= '0;
            r_int    <= '0;
            r_prevd  <= '0;
            r_ff     <= '0;
            r_outr   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // drop valid once taken, unless a new result loads this cycle
            if (o_out.ready && !(r_state == ST_OUT && w_free)) r_ovalid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (w_acc) begin
                        if (i_in.cmd) begin
                            // clear: feedforward term survives
                            r_eh0   <= '0;
                            r_eh1   <= '0;
                            r_eh2   <= '0;
                            r_dh0   <= '0;
                            r_dh1   <= '0;
                            r_int   <= '0;
                            r_prevd <= '0;
                            r_outr  <= '0;
                        end else begin
                            r_eh2 <= r_eh1;
                            r_eh1 <= r_eh0;
                            r_eh0 <= sat_w(XW'(i_in.target_value)
                                           - XW'(i_in.measured_value));
                            r_set <= i_in.target_value;
                        end
                    end
                end
                ST_FF1W: if (mul_done) r_ff <= clamp_m(mul_res, {1'b0, r_ffl});
                ST_FF3W: if (mul_done) r_ff <= mul_res;
                ST_PW, ST_IPW: if (mul_done) r_p <= mul_res;
                ST_IW: begin
                    if (mul_done) begin
                        r_int <= clamp_m(add_s(r_int, mul_res), r_lim_i);
                        r_dh1 <= r_dh0;
                        r_dh0 <= sub_s(r_eh0, r_eh1);
                    end
                end
                ST_IIW: begin
                    if (mul_done) begin
                        r_int <= w_sep ? '0 : mul_res;
                        r_dh1 <= r_dh0;
                        // second difference e0 - 2e1 + e2
                        r_dh0 <= add_s(sub_s(r_eh0, sat_w(XW'(r_eh1) <<< 1)), r_eh2);
                    end
                end
                ST_KW:  if (mul_done) r_k   <= mul_res;
                ST_T1W: if (mul_done) r_acc <= mul_res;
                ST_T2W: if (mul_done) r_acc <= add_s(r_acc, mul_res);
                ST_T3W: if (mul_done) r_acc <= sub_s(r_acc, mul_res);
                ST_DW:  if (mul_done) r_acc <= mul_res;
                ST_SUM1: begin
                    r_prevd <= r_acc;
                    r_p     <= r_mode[0] ? add_s(r_outr, r_p) : add_s(r_p, r_int);
                end
                ST_SUM2: begin
                    r_p <= r_mode[0] ? add_s(r_p, r_int) : add_s(r_p, r_acc);
                end
                ST_SUM3: begin
                    r_outr <= clamp_m(r_mode[0] ? sub_s(r_p, r_acc) : add_s(r_p, r_ff),
                                      r_lim_o);
                end
                ST_OUT: begin
                    if (w_free) begin
                        r_drive  <= w_drive;
                        r_ovalid <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------- checks ----------------
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in.cmd) |=> (r_outr == '0) && (r_state == ST_OUT))
        else $error("clear transaction did not zero the output");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && w_free) |=> o_out.valid && (r_state == ST_IDLE))
        else $error("result not presented after sequence end");

    a_mul_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state != ST_IDLE))
        else $error("multiplier finished with no step in flight");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for pid_controller_pos_delta
// Drives control steps and clears through the valid/ready input channel under
// several register settings, predicts every drive value in fixed point and
// compares each output transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import pcd_pkg::*;

    localparam longint VMAX     = 64'sd2147483647;
    localparam longint VMIN     = -64'sd2147483648;
    localparam int     WD_LIMIT = 5000;   // idle cycles before giving up
    localparam int     N_PHASES = 9;
    localparam int     N_RAND   = 170;    // random steps per setting

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;

    pcd_in_if  in_ch ();
    pcd_out_if out_ch ();

    pid_controller_pos_delta uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // ---------------- predictor state (mirror of the controller) -----------
    logic [2:0] p_mode;
    longint     p_kp, p_ki, p_kd, p_kff, p_knee;
    longint     p_lim_int, p_lim_out, p_ff_lim;
    longint     err_hist [3];
    longint     dif_hist [2];
    longint     integ, last_d, ff_val, drive_acc;

    logic signed [31:0] drive_q [$];   // expected drive values, oldest first
    int  n_fail = 0;
    int  idle_cycles = 0;
    bit  no_gaps;                      // stretch with no idling on either side

    function automatic longint sat_dw(longint v);
        if (v > VMAX) return VMAX;
        if (v < VMIN) return VMIN;
        return v;
    endfunction

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint clamp_mag(longint v, longint m);
        if (v > m) return m;
        if (v < -m) return -m;
        return v;
    endfunction

    // Q16.16 product, truncated toward zero, saturated
    function automatic longint qmul(longint a, longint c);
        bit                neg;
        longint unsigned   ua, uc, hi, lo, m;
        longint            r;
        neg = (a < 0) != (c < 0);
        ua  = mag(a);
        uc  = mag(c);
        hi  = (ua >> 24) * uc;
        lo  = (ua & 64'hFFFFFF) * uc;
        if (hi >= (64'd1 << 54)) m = 64'd1 << 62;
        else m = (hi << 8) + (lo >> 16);
        if (m > (64'd1 << 62)) m = 64'd1 << 62;
        r = longint'(m);
        return sat_dw(neg ? -r : r);
    endfunction

    function automatic longint deriv_term(bit filt);
        longint k, t;
        if (filt) begin
            k = qmul(p_kd, longint'(K_OMA));
            t = sat_dw(qmul(dif_hist[0], k) + qmul(last_d, longint'(K_A)));
            return sat_dw(t - qmul(dif_hist[1], k));
        end
        return qmul(dif_hist[0], p_kd);
    endfunction

    function automatic logic signed [31:0] control_step(logic cmd,
            logic signed [31:0] tgt, logic signed [31:0] meas);
        t_opt   opt;
        longint sp, e0, p, i, d, o, as, ak, r;
        opt = t_opt'(p_mode[2:1]);
        if (cmd) begin
            err_hist = '{0, 0, 0};
            dif_hist = '{0, 0};
            integ = 0; last_d = 0; drive_acc = 0;
            return 32'sd0;
        end
        sp = tgt;
        e0 = sat_dw(sp - longint'(meas));
        err_hist[2] = err_hist[1];
        err_hist[1] = err_hist[0];
        err_hist[0] = e0;
        if (!p_mode[0]) begin
            as = mag(sp);
            ak = mag(p_knee);
            if (as > ak) begin
                ff_val = clamp_mag(qmul(sp, p_kff), p_ff_lim);
            end else if (p_knee != 0) begin
                r = (as << 16) / (ak + 65536);
                ff_val = qmul(qmul(r, p_kff), sp);
            end
            p = qmul(e0, p_kp);
            integ = clamp_mag(sat_dw(integ + qmul(e0, p_ki)), p_lim_int);
            dif_hist[1] = dif_hist[0];
            dif_hist[0] = sat_dw(e0 - err_hist[1]);
            d = deriv_term(opt == OPT_FILT);
            o = sat_dw(sat_dw(sat_dw(p + integ) + d) + ff_val);
        end else begin
            p = qmul(sat_dw(e0 - err_hist[1]), p_kp);
            i = qmul(e0, p_ki);
            if (opt == OPT_SEP && mag(e0) > longint'(K_SEP)) i = 0;
            integ = i;
            dif_hist[1] = dif_hist[0];
            dif_hist[0] = sat_dw(sat_dw(e0 - sat_dw(2 * err_hist[1])) + err_hist[2]);
            d = deriv_term(opt == OPT_FILT || opt == OPT_FORCE);
            o = sat_dw(sat_dw(sat_dw(drive_acc + p) + i) - d);
        end
        last_d = d;
        drive_acc = clamp_mag(o, p_lim_out);
        return drive_acc[31:0];
    endfunction

    // ---------------- register writes (block idle) ---------------------------
    task automatic write_reg(t_reg_idx idx, logic [63:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_MODE:     p_mode = data[2:0];
            REG_GAIN_P:   p_kp = longint'(signed'(data[31:0]));
            REG_GAIN_I:   p_ki = longint'(signed'(data[31:0]));
            REG_GAIN_D:   p_kd = longint'(signed'(data[31:0]));
            REG_LIMITS: begin
                p_lim_int = longint'({32'd0, data[63:32]});
                p_lim_out = longint'({32'd0, data[31:0]});
            end
            REG_GAIN_FF:  p_kff = longint'(signed'(data[31:0]));
            REG_FF_KNEE:  p_knee = longint'(signed'(data[31:0]));
            REG_FF_LIMIT: p_ff_lim = longint'({33'd0, data[30:0]});
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // gain: mostly modest (within +/-4.0), sometimes anything or an extreme
    function automatic logic [31:0] rand_gain();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom();
            default: return 32'($signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000);
        endcase
    endfunction

    function automatic logic [31:0] rand_lim();
        case ($urandom_range(0, 5))
            0: return 32'hFFFF_FFFF;
            1: return 32'd0;
            2: return $urandom();
            default: return $urandom_range(32'h1_0000, 32'h200_0000);
        endcase
    endfunction

    task automatic configure(int ph);
        logic [2:0] md;
        // let a late clear or step settle before touching the registers
        @(posedge i_clk);
        wait (drive_q.size() == 0);
        repeat (12) @(posedge i_clk);
        md = (ph < 8) ? 3'(ph) : 3'($urandom_range(0, 7));
        write_reg(REG_MODE, {61'd0, md});
        if (ph == 8) begin
            // extremes: widest gains, open limits
            write_reg(REG_GAIN_P, {32'd0, 32'h7FFF_FFFF});
            write_reg(REG_GAIN_I, {32'd0, 32'h8000_0000});
            write_reg(REG_GAIN_D, {32'd0, 32'h7FFF_FFFF});
            write_reg(REG_LIMITS, 64'hFFFF_FFFF_FFFF_FFFF);
            write_reg(REG_GAIN_FF, {32'd0, 32'h8000_0000});
            write_reg(REG_FF_KNEE, {32'd0, 32'h8000_0000});
            write_reg(REG_FF_LIMIT, 64'h7FFF_FFFF);
        end else begin
            write_reg(REG_GAIN_P, {32'd0, rand_gain()});
            write_reg(REG_GAIN_I, {32'd0, rand_gain()});
            write_reg(REG_GAIN_D, {32'd0, rand_gain()});
            write_reg(REG_LIMITS, {rand_lim(), rand_lim()});
            write_reg(REG_GAIN_FF, {32'd0, rand_gain()});
            // zero knee on some phases: a zero target keeps the old feedforward
            write_reg(REG_FF_KNEE, {32'd0, ($urandom_range(0, 2) == 0) ? 32'd0
                                           : rand_gain()});
            write_reg(REG_FF_LIMIT, {33'd0, 31'(rand_lim())});
        end
    endtask

    // ---------------- input side ---------------------------------------------
    task automatic send(logic cmd, logic signed [31:0] tgt, logic signed [31:0] meas);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.cmd            <= cmd;
        in_ch.target_value   <= tgt;
        in_ch.measured_value <= meas;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // input transaction accepted: queue what the controller must produce
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready)
            drive_q.push_back(control_step(in_ch.cmd, in_ch.target_value,
                                           in_ch.measured_value));
    end

    // ---------------- output side --------------------------------------------
    initial begin
        int gap;
        out_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (drive_q.size() == 0) begin
                $error("drive_out: unexpected transaction, value %0d", out_ch.drive_out);
                n_fail++;
            end else begin
                if (out_ch.drive_out !== drive_q[0]) begin
                    $error("drive_out: expected %0d, got %0d", drive_q[0],
                           out_ch.drive_out);
                    n_fail++;
                end
                void'(drive_q.pop_front());
            end
        end
    end

    // watchdog: stalls with no transaction on either channel
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------- directed table -----------------------------------------
    typedef struct {
        logic               cmd;
        logic signed [31:0] tgt;
        logic signed [31:0] meas;
    } t_row;

    // Under reset settings every limit is zero, so every drive value is 0.
    localparam int N_ROWS = 14;
    t_row rows [N_ROWS] = '{
        '{1'b1, 32'sd0,          32'sd0},            // clear from reset
        '{1'b0, 32'sh7FFF_FFFF,  32'sh8000_0000},    // error saturates high
        '{1'b0, 32'sh8000_0000,  32'sh7FFF_FFFF},    // error saturates low
        '{1'b0, 32'sd0,          32'sd0},            // zero target, feedforward kept
        '{1'b0, 32'sh7FFF_FFFF,  32'sh7FFF_FFFF},
        '{1'b0, 32'sh8000_0000,  32'sh8000_0000},
        '{1'b0, 32'sh0001_0000,  32'sd0},            // error 1.0
        '{1'b0, 32'sd6554,       32'sd0},            // error at separation edge
        '{1'b0, 32'sd6555,       32'sd0},            // just above it
        '{1'b0, -32'sd6555,      32'sd0},
        '{1'b0, 32'sh0003_0000,  32'sh0001_8000},    // crosses a 2.0 knee
        '{1'b0, -32'sh0001_0000, 32'sh0000_4000},
        '{1'b1, 32'sh1234_5678,  32'sh8765_4321},    // clear mid-history
        '{1'b0, 32'sh0000_8000,  -32'sh0000_8000}
    };

    function automatic logic signed [31:0] rand_val();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2, 3: return $urandom();
            default: return 32'($signed($urandom_range(0, 32'h10_0000)) - 32'sh8_0000);
        endcase
    endfunction

    initial begin
        logic signed [31:0] ref_t, ref_m;
        logic [31:0]        ref_v;
        err_hist = '{0, 0, 0};
        dif_hist = '{0, 0};
        integ = 0; last_d = 0; ff_val = 0; drive_acc = 0;
        p_mode = 3'd0;
        p_kp = 0; p_ki = 0; p_kd = 0; p_kff = 0; p_knee = 0;
        p_lim_int = 0; p_lim_out = 0; p_ff_lim = 0;
        no_gaps = 1'b0;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_MODE;
        i_cfg_data = 64'd0;
        in_ch.valid = 1'b0;
        in_ch.cmd = 1'b0;
        in_ch.target_value = 32'sd0;
        in_ch.measured_value = 32'sd0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: each row must come out as zero
        foreach (rows[r]) begin
            send(rows[r].cmd, rows[r].tgt, rows[r].meas);
        end
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (drive_q.size() == 0);
        repeat (12) @(posedge i_clk);

        // same rows with live gains, a 2.0 knee and incremental separation
        write_reg(REG_MODE, {61'd0, OPT_SEP, 1'b1});
        write_reg(REG_GAIN_P, 64'h0001_0000);
        write_reg(REG_GAIN_I, 64'h0000_8000);
        write_reg(REG_GAIN_D, 64'h0000_4000);
        write_reg(REG_LIMITS, 64'h0100_0000_0200_0000);
        write_reg(REG_GAIN_FF, 64'h0000_C000);
        write_reg(REG_FF_KNEE, 64'h0002_0000);
        write_reg(REG_FF_LIMIT, 64'h0008_0000);
        foreach (rows[r]) begin
            send(rows[r].cmd, rows[r].tgt, rows[r].meas);
        end
        in_ch.valid <= 1'b0;

        // random phases, one per setting
        for (int ph = 0; ph < N_PHASES; ph++) begin
            configure(ph);
            for (int k = 0; k < N_RAND; k++) begin
                if (k % 60 == 0) no_gaps = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 19) == 0) begin
                    send(1'b1, $urandom(), $urandom());
                end else begin
                    // measurement usually tracks the target, so the loop
                    // stays out of saturation most of the time
                    ref_t = rand_val();
                    ref_v = $urandom_range(0, 32'h4_0000);
                    ref_m = ($urandom_range(0, 3) == 0) ? rand_val()
                            : 32'(ref_t - $signed(ref_v) + 32'sh2_0000);
                    send(1'b0, ref_t, ref_m);
                end
            end
            in_ch.valid <= 1'b0;
            no_gaps = 1'b0;
        end

        @(posedge i_clk);
        wait (drive_q.size() == 0);
        repeat (20) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
